@@ design/est_pkg.sv @@
// ----------------------------------------------------------------------------
// est_pkg
// Shared constants, types and control codes of the exponential search table.
// ----------------------------------------------------------------------------
package est_pkg;

	localparam int POS_W       = 10;
	localparam int TABLE_DEPTH = 2 ** POS_W;
	localparam int KEY_WIDTH   = 32;
	localparam int CNT_W       = POS_W + 1;
	localparam int CFG_W       = 11;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DBL_RD,
		ST_DBL_CMP,
		ST_BIN_INIT,
		ST_BIN_RD,
		ST_BIN_CMP,
		ST_FIN_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_BOUND,
		RD_MID,
		RD_LOW
	} rd_sel_t;

	typedef struct packed {
		logic    start;
		logic    wr_en;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    dbl_step;
		logic    bin_init;
		logic    bin_step;
		logic    res_set;
		logic    out_push;
	} cmd_t;

	typedef struct packed {
		logic cfg_zero;
		logic bound_lt_n;
		logic probe_lt_key;
		logic bin_open;
		logic key_eq;
		logic out_free;
	} stat_t;

endpackage

@@ design/est_ctrl.sv @@
// ----------------------------------------------------------------------------
// est_ctrl
// Sequencer for one item: load, doubling probes, binary probes, result push.
// ----------------------------------------------------------------------------
module est_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  est_pkg::stat_t  stat,
	output est_pkg::cmd_t   cmd
);

	est_pkg::state_t state_q;
	est_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= est_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.rd_sel   = est_pkg::RD_BOUND;
		case (state_q)
			est_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == est_pkg::MODE_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = stat.cfg_zero ? est_pkg::ST_DONE : est_pkg::ST_DBL_RD;
					end
				end
			end
			est_pkg::ST_DBL_RD: begin
				if (stat.bound_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = est_pkg::RD_BOUND;
					state_d    = est_pkg::ST_DBL_CMP;
				end else begin
					state_d = est_pkg::ST_BIN_INIT;
				end
			end
			est_pkg::ST_DBL_CMP: begin
				if (stat.probe_lt_key) begin
					cmd.dbl_step = 1'b1;
					state_d      = est_pkg::ST_DBL_RD;
				end else begin
					state_d = est_pkg::ST_BIN_INIT;
				end
			end
			est_pkg::ST_BIN_INIT: begin
				cmd.bin_init = 1'b1;
				state_d      = est_pkg::ST_BIN_RD;
			end
			est_pkg::ST_BIN_RD: begin
				cmd.rd_en = 1'b1;
				if (stat.bin_open) begin
					cmd.rd_sel = est_pkg::RD_MID;
					state_d    = est_pkg::ST_BIN_CMP;
				end else begin
					cmd.rd_sel = est_pkg::RD_LOW;
					state_d    = est_pkg::ST_FIN_CMP;
				end
			end
			est_pkg::ST_BIN_CMP: begin
				if (stat.key_eq) begin
					cmd.res_set = 1'b1;
					state_d     = est_pkg::ST_DONE;
				end else begin
					cmd.bin_step = 1'b1;
					state_d      = est_pkg::ST_BIN_RD;
				end
			end
			est_pkg::ST_FIN_CMP: begin
				cmd.res_set = 1'b1;
				state_d     = est_pkg::ST_DONE;
			end
			est_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = est_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = est_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/est_datapath.sv @@
// ----------------------------------------------------------------------------
// est_datapath
// Key table, search bounds, probe compare and the output register.
// ----------------------------------------------------------------------------
module est_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [est_pkg::CFG_W-1:0]           cfg_data,
	input  logic [est_pkg::POS_W-1:0]           load_position,
	input  logic signed [est_pkg::KEY_WIDTH-1:0] item_key,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                found,
	output logic [est_pkg::POS_W-1:0]           match_position,
	input  est_pkg::cmd_t                       cmd,
	output est_pkg::stat_t                      stat
);

	logic signed [est_pkg::KEY_WIDTH-1:0] key_mem [est_pkg::TABLE_DEPTH];

	logic [est_pkg::CFG_W-1:0]            used_count_q;
	logic signed [est_pkg::KEY_WIDTH-1:0] key_q;
	logic signed [est_pkg::KEY_WIDTH-1:0] rd_data_q;
	logic [est_pkg::CNT_W-1:0]            n_q;
	logic [est_pkg::CNT_W-1:0]            bound_q;
	logic [est_pkg::POS_W-1:0]            low_q;
	logic [est_pkg::POS_W-1:0]            high_q;
	logic [est_pkg::POS_W-1:0]            addr_q;
	logic                                 res_found_q;
	logic [est_pkg::POS_W-1:0]            res_pos_q;
	logic                                 out_valid_q;
	logic                                 found_q;
	logic [est_pkg::POS_W-1:0]            match_pos_q;

	logic [est_pkg::CNT_W-1:0] n_clip;
	logic [est_pkg::CNT_W-1:0] n_last;
	logic [est_pkg::CNT_W-1:0] mid_sum;
	logic [est_pkg::POS_W-1:0] mid;
	logic [est_pkg::POS_W-1:0] rd_addr;
	logic [est_pkg::CNT_W-1:0] high_init;

	// counts above the depth act as the full table
	assign n_clip = (used_count_q > est_pkg::CFG_W'(est_pkg::TABLE_DEPTH))
		? est_pkg::CNT_W'(est_pkg::TABLE_DEPTH) : est_pkg::CNT_W'(used_count_q);
	assign n_last    = n_q - est_pkg::CNT_W'(1);
	assign high_init = (bound_q < n_last) ? bound_q : n_last;
	assign mid_sum   = est_pkg::CNT_W'(high_q) + est_pkg::CNT_W'(low_q);
	assign mid       = mid_sum[est_pkg::CNT_W-1:1];

	always_comb begin
		case (cmd.rd_sel)
			est_pkg::RD_BOUND: rd_addr = bound_q[est_pkg::POS_W-1:0];
			est_pkg::RD_MID:   rd_addr = mid;
			est_pkg::RD_LOW:   rd_addr = low_q;
			default:           rd_addr = low_q;
		endcase
	end

	assign stat.cfg_zero     = (used_count_q == '0);
	assign stat.bound_lt_n   = (bound_q < n_q);
	assign stat.probe_lt_key = (rd_data_q < key_q);
	assign stat.bin_open     = (high_q > low_q);
	assign stat.key_eq       = (rd_data_q == key_q);
	assign stat.out_free     = !out_valid_q || out_ready;

	// table port: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[load_position] <= item_key;
		end
		if (cmd.rd_en) begin
			rd_data_q <= key_mem[rd_addr];
			addr_q    <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q       <= item_key;
			n_q         <= n_clip;
			bound_q     <= est_pkg::CNT_W'(1);
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
		if (cmd.dbl_step) begin
			bound_q <= {bound_q[est_pkg::CNT_W-2:0], 1'b0};
		end
		if (cmd.bin_init) begin
			low_q  <= bound_q[est_pkg::CNT_W-1:1];
			high_q <= high_init[est_pkg::POS_W-1:0];
		end
		if (cmd.bin_step) begin
			if (key_q <= rd_data_q) begin
				high_q <= addr_q;
			end else begin
				low_q <= addr_q + est_pkg::POS_W'(1);
			end
		end
		if (cmd.res_set) begin
			res_found_q <= stat.key_eq;
			res_pos_q   <= stat.key_eq ? addr_q : '0;
		end
		if (cmd.out_push) begin
			found_q     <= res_found_q;
			match_pos_q <= res_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				used_count_q <= cfg_data;
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = match_pos_q;

endmodule

@@ design/exponential_search_table_top.sv @@
// ----------------------------------------------------------------------------
// exponential_search_table_top
// Sorted table of signed keys with load and exponential search items.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// --------+----------------------+---------------------------------------
// in      | in_valid / in_ready  | mode, load_position, item_key
// out     | out_valid / out_ready| found, match_position
// cfg     | cfg_valid / cfg_ready| cfg_data (used_count)
//
// a load gives no result and leaves the input ready for the next item; a
// search makes table probes (one registered read of the key table, one
// compare each), 2*log2(n) probes worst case; an empty table is answered
// without a probe.
// reset clears the controller, used_count and the output valid; the table
// itself is not cleared. a finished search waits in the controller while
// the output register is held by out_ready low; new items are taken meanwhile
// only after that result moves into the output register.
module exponential_search_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [est_pkg::POS_W-1:0]           load_position,
	input  logic signed [est_pkg::KEY_WIDTH-1:0] item_key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [est_pkg::POS_W-1:0]           match_position,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [est_pkg::CFG_W-1:0]           cfg_data
);

	est_pkg::cmd_t  cmd;
	est_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	est_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	est_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.load_position  (load_position),
		.item_key       (item_key),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.found          (found),
		.match_position (match_position),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

@@ design/est_checker.sv @@
// ----------------------------------------------------------------------------
// est_checker
// Port-level checks of the exponential search table, bound to the top level.
// ----------------------------------------------------------------------------
module est_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                mode,
	input logic [est_pkg::POS_W-1:0]           load_position,
	input logic signed [est_pkg::KEY_WIDTH-1:0] item_key,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                found,
	input logic [est_pkg::POS_W-1:0]           match_position,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [est_pkg::CFG_W-1:0]           cfg_data
);

	// stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(found) && $stable(match_position))
		else $error("result changed while stalled");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_position == '0)
		else $error("miss with nonzero position");

	// a search transaction occupies the block
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == est_pkg::MODE_SEARCH |=> !in_ready)
		else $error("input taken right after a search");

	// a load transaction leaves the input ready in the next cycle
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == est_pkg::MODE_LOAD |=> in_ready)
		else $error("load stalled the input");

endmodule

bind exponential_search_table_top est_checker u_est_checker (.*);

@@ dv/exponential_search_table_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exponential_search_table_top_tb
// Loads sorted key tables, runs exponential searches over them at a range of
// used counts and traffic patterns, and compares every found flag and match
// position against a shadow table searched in the same order, or typed values.
// ----------------------------------------------------------------------------
module exponential_search_table_top_tb;
	import est_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 64;
	localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  pos;
	} lookup_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_LOAD,
		ROW_SEARCH
	} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic [POS_W-1:0]             pos;
		logic signed [KEY_WIDTH-1:0]  key;
		logic [CFG_W-1:0]             count;
		logic                         typed;
		logic                         exp_found;
		logic [POS_W-1:0]             exp_pos;
	} stim_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// empty table straight out of reset, then with the count written
		'{ROW_SEARCH, 10'd0, 32'sd5, 11'd0, 1'b1, 1'b0, 10'd0},
		'{ROW_CFG, 10'd0, 32'sd0, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, KEY_MIN, 11'd0, 1'b1, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd0, KEY_MIN, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd1, -32'sd100, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd2, -32'sd1, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd3, 32'sd0, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd4, 32'sd7, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd5, 32'sd1000, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd6, 32'sh7fff_fffe, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd7, KEY_MAX, 11'd0, 1'b0, 1'b0, 10'd0},
		// single entry table
		'{ROW_CFG, 10'd0, 32'sd0, 11'd1, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, KEY_MIN, 11'd0, 1'b1, 1'b1, 10'd0},
		'{ROW_SEARCH, 10'd0, KEY_MAX, 11'd0, 1'b1, 1'b0, 10'd0},
		'{ROW_CFG, 10'd0, 32'sd0, 11'd8, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, KEY_MIN, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, KEY_MAX, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, -32'sd1, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, 32'sd7, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, 32'sd8, 11'd0, 1'b0, 1'b0, 10'd0},
		// break the ordering in the middle
		'{ROW_LOAD, 10'd3, 32'sd5000, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, 32'sd5000, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, 32'sd0, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_LOAD, 10'd1023, -32'sd5, 11'd0, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0, -32'sd100, 11'd0, 1'b0, 1'b0, 10'd0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          mode;
	logic [POS_W-1:0]              load_position;
	logic signed [KEY_WIDTH-1:0]   item_key;
	logic                          out_valid;
	logic                          out_ready;
	logic                          found;
	logic [POS_W-1:0]              match_position;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_W-1:0]              cfg_data;

	logic signed [KEY_WIDTH-1:0]   shadow_keys [TABLE_DEPTH];
	logic [CFG_W-1:0]              shadow_count;
	lookup_t                       expected_lookups [$];
	int                            error_count;
	int                            cycle_count;
	int                            send_idle_pct;
	int                            recv_idle_pct;
	int                            rx_hold_cycles;

	exponential_search_table_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.load_position  (load_position),
		.item_key       (item_key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.match_position (match_position),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic lookup_t search_outcome(input logic signed [KEY_WIDTH-1:0] key);
		int      n;
		int      i;
		int      low;
		int      high;
		int      mid;
		lookup_t res;
		res = '0;
		n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
		if (n == 0) begin
			return res;
		end
		// doubling phase, then binary search inside the last doubling step
		i = 1;
		while (i < n && shadow_keys[i] < key) begin
			i = i * 2;
		end
		low = i / 2;
		high = (i < n - 1) ? i : n - 1;
		while (high > low) begin
			mid = (high + low) / 2;
			if (shadow_keys[mid] == key) begin
				res.found = 1'b1;
				res.pos = mid[POS_W-1:0];
				return res;
			end
			if (key <= shadow_keys[mid]) begin
				high = mid;
			end else begin
				low = mid + 1;
			end
		end
		if (shadow_keys[low] == key) begin
			res.found = 1'b1;
			res.pos = low[POS_W-1:0];
		end
		return res;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic m, input logic [POS_W-1:0] p,
			input logic signed [KEY_WIDTH-1:0] k, input logic typed, input lookup_t typed_res);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		load_position <= p;
		item_key <= k;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_LOAD) begin
			shadow_keys[p] = k;
		end else begin
			expected_lookups.push_back(typed ? typed_res : search_outcome(k));
		end
		@(negedge clk);
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_lookups.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// loads leave no result, so let the last one finish before touching config
	task automatic drain();
		hold_input();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_used_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int rebuild_len, input int count, input int n_items,
			input int idle_mode, input bit hold_rx, input bit pause_tx);
		int                           n;
		int                           r;
		int                           p;
		longint                       acc;
		longint                       step_max;
		longint                       lo;
		longint                       hi;
		longint unsigned              r64;
		logic signed [KEY_WIDTH-1:0]  k;
		lookup_t                      none;
		none = '0;
		drain();
		case (idle_mode)
			0: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			1: begin
				send_idle_pct = 46;
				recv_idle_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_idle_pct = 46;
			end
			default: begin
				send_idle_pct = 23;
				recv_idle_pct = 23;
			end
		endcase
		write_used_count(count[CFG_W-1:0]);
		if (rebuild_len > 0) begin
			// ascending keys: dense with duplicates, moderate, or spread over the range
			case ($urandom_range(0, 2))
				0: step_max = 3;
				1: step_max = 1000;
				default: step_max = 64'd4294967295 / rebuild_len;
			endcase
			if (step_max > 1000) begin
				acc = longint'(KEY_MIN) + $urandom_range(0, 255);
			end else begin
				acc = longint'($signed($urandom));
			end
			for (p = 0; p < rebuild_len; p++) begin
				send_item(MODE_LOAD, p[POS_W-1:0], acc[KEY_WIDTH-1:0], 1'b0, none);
				r64 = {$urandom, $urandom};
				acc = acc + longint'(r64 % longint'(step_max + 1));
				if (acc > longint'(KEY_MAX)) begin
					acc = longint'(KEY_MAX);
				end
			end
		end
		n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		if (hold_rx) begin
			rx_hold_cycles = 300;
		end
		for (int i = 0; i < n_items; i++) begin
			if (pause_tx && i == n_items / 2) begin
				hold_input();
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				// rewrite one entry with a key that keeps its neighbors in order
				p = $urandom_range(0, n - 1);
				lo = (p > 0) ? longint'(shadow_keys[p-1]) : longint'(KEY_MIN);
				hi = (p < n - 1) ? longint'(shadow_keys[p+1]) : longint'(KEY_MAX);
				if (hi < lo) begin
					k = shadow_keys[p];
				end else begin
					r64 = {$urandom, $urandom};
					acc = lo + longint'(r64 % longint'(hi - lo + 1));
					k = acc[KEY_WIDTH-1:0];
				end
				send_item(MODE_LOAD, p[POS_W-1:0], k, 1'b0, none);
			end else if (r < 15) begin
				send_item(MODE_LOAD, POS_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom,
					1'b0, none);
			end else begin
				r = $urandom_range(0, 99);
				p = $urandom_range(0, n - 1);
				if (r < 55) begin
					k = shadow_keys[p];
				end else if (r < 75) begin
					k = shadow_keys[p] + (($urandom_range(0, 1) == 1) ? 1 : -1);
				end else if (r < 85) begin
					k = $urandom;
				end else if (r < 90) begin
					k = ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
				end else if (r < 95) begin
					k = shadow_keys[0] - 1;
				end else begin
					k = shadow_keys[n-1] + 1;
				end
				send_item(MODE_SEARCH, POS_W'($urandom), k, 1'b0, none);
			end
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ready <= 1'b0;
			rx_hold_cycles = rx_hold_cycles - 1;
		end else begin
			out_ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		lookup_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lookups.size() == 0) begin
				$error("result transaction with no search pending");
				error_count++;
			end else begin
				exp_res = expected_lookups.pop_front();
				if (found !== exp_res.found) begin
					$error("found: expected %0d, actual %0d", exp_res.found, found);
					error_count++;
				end
				if (match_position !== exp_res.pos) begin
					$error("match_position: expected %0d, actual %0d", exp_res.pos,
						match_position);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("exponential_search_table_top_tb: errors");
			$finish;
		end
	end

	initial begin
		lookup_t row_res;
		int      small_len;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		load_position = '0;
		item_key = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		shadow_count = '0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row_res.found = DIRECTED_ROWS[i].exp_found;
			row_res.pos = DIRECTED_ROWS[i].exp_pos;
			case (DIRECTED_ROWS[i].kind)
				ROW_CFG: begin
					drain();
					write_used_count(DIRECTED_ROWS[i].count);
				end
				ROW_LOAD: begin
					send_item(MODE_LOAD, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].key, 1'b0,
						row_res);
				end
				default: begin
					send_item(MODE_SEARCH, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].key,
						DIRECTED_ROWS[i].typed, row_res);
				end
			endcase
		end

		// small tables first, then the full table, counts past its depth and a random count
		small_len = $urandom_range(1, 12);
		run_phase(small_len, small_len, 80, 0, 1'b0, 1'b0);
		small_len = $urandom_range(13, 60);
		run_phase(small_len, small_len, 100, 1, 1'b0, 1'b1);
		run_phase(TABLE_DEPTH, TABLE_DEPTH, 120, 2, 1'b1, 1'b0);
		run_phase(0, 2047, 80, 3, 1'b0, 1'b0);
		run_phase(0, $urandom_range(TABLE_DEPTH + 1, 2046), 60, 0, 1'b0, 1'b0);
		run_phase(0, $urandom_range(1, TABLE_DEPTH), 80, 3, 1'b0, 1'b0);

		drain();
		if (error_count == 0) begin
			$display("exponential_search_table_top_tb: clean");
		end else begin
			$display("exponential_search_table_top_tb: errors");
		end
		$finish;
	end

endmodule
